@@ hdl/msti_pkg.sv @@
package msti_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int RADIUS_WIDTH = 31;
    localparam int TIME_BITS    = 17;
    localparam int TIME_FRAC    = TIME_BITS - 1;
    localparam int RR_WIDTH     = 2 * RADIUS_WIDTH;

    localparam int D_WIDTH  = COORD_WIDTH + 1;
    localparam int V_WIDTH  = COORD_WIDTH + 2;
    localparam int S_WIDTH  = (2 * V_WIDTH + 2 > RR_WIDTH + 2) ? 2 * V_WIDTH + 2 : RR_WIDTH + 2;
    localparam int F_WIDTH  = S_WIDTH + 3;
    localparam int LO_WIDTH = (S_WIDTH + 1) / 2;
    localparam int HI_WIDTH = S_WIDTH - LO_WIDTH;
    localparam int P_WIDTH  = 2 * S_WIDTH;
    localparam int G_WIDTH  = S_WIDTH + 2 * TIME_BITS + 2;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(65536);
    localparam logic [TIME_BITS-1:0]    TIME_ONE     = TIME_BITS'(1) << TIME_FRAC;

    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_HIT     = 2'd1,
        STATUS_OVERLAP = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_start_x;
        logic signed [COORD_WIDTH-1:0] first_start_y;
        logic signed [COORD_WIDTH-1:0] first_start_z;
        logic signed [COORD_WIDTH-1:0] first_end_x;
        logic signed [COORD_WIDTH-1:0] first_end_y;
        logic signed [COORD_WIDTH-1:0] first_end_z;
        logic signed [COORD_WIDTH-1:0] second_start_x;
        logic signed [COORD_WIDTH-1:0] second_start_y;
        logic signed [COORD_WIDTH-1:0] second_start_z;
        logic signed [COORD_WIDTH-1:0] second_end_x;
        logic signed [COORD_WIDTH-1:0] second_end_y;
        logic signed [COORD_WIDTH-1:0] second_end_z;
    } in_t;

    typedef struct packed {
        status_t                contact_status;
        logic [TIME_BITS-1:0]   impact_time;
    } out_t;

    typedef struct packed {
        logic signed [S_WIDTH-1:0] a;
        logic signed [S_WIDTH-1:0] h;
        logic signed [S_WIDTH-1:0] c0;
    } moments_t;

    typedef struct packed {
        logic                      overlap;
        logic                      hit;
        logic signed [S_WIDTH-1:0] a;
        logic signed [S_WIDTH-1:0] h;
        logic [TIME_BITS-1:0]      k;
        logic signed [G_WIDTH-1:0] ak;
        logic signed [G_WIDTH-1:0] g;
    } step_t;

endpackage

@@ hdl/msti_geom.sv @@
module msti_geom (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  msti_pkg::in_t     in_data,
    output logic              valid,
    output msti_pkg::moments_t moments
);

    localparam int DW = msti_pkg::D_WIDTH;
    localparam int VW = msti_pkg::V_WIDTH;
    localparam int SW = msti_pkg::S_WIDTH;

    logic signed [VW-1:0] p0[3];
    logic signed [VW-1:0] p1[3];
    logic signed [VW-1:0] q0[3];
    logic signed [VW-1:0] q1[3];

    logic signed [DW-1:0] d_next[3];
    logic signed [DW-1:0] d_reg[3];
    logic signed [VW-1:0] v_next[3];
    logic signed [VW-1:0] v_reg[3];

    logic signed [2*DW-1:0]  dd_next[3];
    logic signed [2*DW-1:0]  dd_reg[3];
    logic signed [2*VW-1:0]  vv_next[3];
    logic signed [2*VW-1:0]  vv_reg[3];
    logic signed [DW+VW-1:0] dv_next[3];
    logic signed [DW+VW-1:0] dv_reg[3];

    msti_pkg::moments_t moments_next;
    msti_pkg::moments_t moments_reg;

    logic [2:0] valid_next;
    logic [2:0] valid_reg;

    always_comb
    begin
        p0[0] = VW'(in_data.first_start_x);
        p0[1] = VW'(in_data.first_start_y);
        p0[2] = VW'(in_data.first_start_z);
        p1[0] = VW'(in_data.first_end_x);
        p1[1] = VW'(in_data.first_end_y);
        p1[2] = VW'(in_data.first_end_z);
        q0[0] = VW'(in_data.second_start_x);
        q0[1] = VW'(in_data.second_start_y);
        q0[2] = VW'(in_data.second_start_z);
        q1[0] = VW'(in_data.second_end_x);
        q1[1] = VW'(in_data.second_end_y);
        q1[2] = VW'(in_data.second_end_z);
        for (int i = 0; i < 3; i++)
        begin
            d_next[i]  = DW'(p0[i] - q0[i]);
            v_next[i]  = (p1[i] - p0[i]) - (q1[i] - q0[i]);
            dd_next[i] = d_reg[i] * d_reg[i];
            vv_next[i] = v_reg[i] * v_reg[i];
            dv_next[i] = d_reg[i] * v_reg[i];
        end
        moments_next.a  = SW'(vv_reg[0]) + SW'(vv_reg[1]) + SW'(vv_reg[2]);
        moments_next.h  = SW'(dv_reg[0]) + SW'(dv_reg[1]) + SW'(dv_reg[2]);
        moments_next.c0 = SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
        valid_next = {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]  <= d_next[i];
                v_reg[i]  <= v_next[i];
                dd_reg[i] <= dd_next[i];
                vv_reg[i] <= vv_next[i];
                dv_reg[i] <= dv_next[i];
            end
            moments_reg <= moments_next;
        end
    end

    assign valid   = valid_reg[2];
    assign moments = moments_reg;

endmodule

@@ hdl/msti_disc.sv @@
module msti_disc (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   in_valid,
    input  msti_pkg::moments_t                     moments,
    input  logic [msti_pkg::RR_WIDTH-1:0]          rr,
    output logic                                   valid,
    output msti_pkg::step_t                        step
);

    localparam int SW = msti_pkg::S_WIDTH;
    localparam int FW = msti_pkg::F_WIDTH;
    localparam int LW = msti_pkg::LO_WIDTH;
    localparam int HW = msti_pkg::HI_WIDTH;
    localparam int PW = msti_pkg::P_WIDTH;
    localparam int GW = msti_pkg::G_WIDTH;

    // stage 1: offset c, early rejects
    logic signed [SW-1:0] rr_ext;
    logic signed [SW-1:0] c_next;
    logic signed [FW-1:0] f1;
    logic                 overlap_next;
    logic                 cand_next;

    logic signed [SW-1:0] a1_reg;
    logic signed [SW-1:0] h1_reg;
    logic signed [SW-1:0] c1_reg;
    logic                 overlap1_reg;
    logic                 cand1_reg;

    // stage 2: partial products
    logic [SW-1:0]       ua;
    logic [SW-1:0]       uc;
    logic [SW-1:0]       uh;
    logic [2*LW-1:0]     hh_ll_next, ac_ll_next, hh_ll_reg, ac_ll_reg;
    logic [LW+HW-1:0]    hh_lh_next, ac_lh_next, hh_lh_reg, ac_lh_reg;
    logic [LW+HW-1:0]    hh_hl_next, ac_hl_next, hh_hl_reg, ac_hl_reg;
    logic [2*HW-1:0]     hh_hh_next, ac_hh_next, hh_hh_reg, ac_hh_reg;
    logic signed [SW-1:0] a2_reg;
    logic signed [SW-1:0] h2_reg;
    logic signed [SW-1:0] c2_reg;
    logic                 overlap2_reg;
    logic                 cand2_reg;

    // stage 3: discriminant sign
    logic [PW-1:0]     hsq;
    logic [PW-1:0]     acp;
    msti_pkg::step_t   step_next;
    msti_pkg::step_t   step_reg;

    logic [2:0] valid_next;
    logic [2:0] valid_reg;

    always_comb
    begin
        rr_ext       = $signed(SW'(rr));
        c_next       = moments.c0 - rr_ext;
        overlap_next = (moments.c0 <= rr_ext);
        f1           = FW'(moments.a) + (FW'(moments.h) <<< 1) + FW'(c_next);
        cand_next    = (moments.a != '0) && moments.h[SW-1]
                       && (f1[FW-1] || (f1 == '0) || (-moments.h <= moments.a));

        ua = a1_reg;
        uc = c1_reg;
        uh = -h1_reg;
        hh_ll_next = uh[LW-1:0] * uh[LW-1:0];
        hh_lh_next = uh[LW-1:0] * uh[SW-1:LW];
        hh_hl_next = uh[SW-1:LW] * uh[LW-1:0];
        hh_hh_next = uh[SW-1:LW] * uh[SW-1:LW];
        ac_ll_next = ua[LW-1:0] * uc[LW-1:0];
        ac_lh_next = ua[LW-1:0] * uc[SW-1:LW];
        ac_hl_next = ua[SW-1:LW] * uc[LW-1:0];
        ac_hh_next = ua[SW-1:LW] * uc[SW-1:LW];

        hsq = PW'(hh_ll_reg) + ((PW'(hh_lh_reg) + PW'(hh_hl_reg)) << LW)
              + (PW'(hh_hh_reg) << (2 * LW));
        acp = PW'(ac_ll_reg) + ((PW'(ac_lh_reg) + PW'(ac_hl_reg)) << LW)
              + (PW'(ac_hh_reg) << (2 * LW));

        step_next.overlap = overlap2_reg;
        step_next.hit     = cand2_reg && (hsq >= acp);
        step_next.a       = a2_reg;
        step_next.h       = h2_reg;
        step_next.k       = '0;
        step_next.ak      = '0;
        step_next.g       = GW'(c2_reg) <<< (2 * msti_pkg::TIME_FRAC);

        valid_next = {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_reg       <= moments.a;
            h1_reg       <= moments.h;
            c1_reg       <= c_next;
            overlap1_reg <= overlap_next;
            cand1_reg    <= cand_next;

            hh_ll_reg    <= hh_ll_next;
            hh_lh_reg    <= hh_lh_next;
            hh_hl_reg    <= hh_hl_next;
            hh_hh_reg    <= hh_hh_next;
            ac_ll_reg    <= ac_ll_next;
            ac_lh_reg    <= ac_lh_next;
            ac_hl_reg    <= ac_hl_next;
            ac_hh_reg    <= ac_hh_next;
            a2_reg       <= a1_reg;
            h2_reg       <= h1_reg;
            c2_reg       <= c1_reg;
            overlap2_reg <= overlap1_reg;
            cand2_reg    <= cand1_reg;

            step_reg     <= step_next;
        end
    end

    assign valid = valid_reg[2];
    assign step  = step_reg;

endmodule

@@ hdl/msti_root_step.sv @@
module msti_root_step #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  msti_pkg::step_t in_step,
    output logic            valid,
    output msti_pkg::step_t step
);

    localparam int GW = msti_pkg::G_WIDTH;

    // try k + 2^BIT: keep it if still at or before the vertex and f(k) >= 0
    logic signed [GW-1:0] a_ext;
    logic signed [GW-1:0] h_ext;
    logic signed [GW-1:0] vert;
    logic signed [GW-1:0] cand_ak;
    logic signed [GW-1:0] cand_g;
    logic                 take;

    msti_pkg::step_t step_next;
    msti_pkg::step_t step_reg;
    logic            valid_reg;

    always_comb
    begin
        a_ext   = GW'(in_step.a);
        h_ext   = GW'(in_step.h);
        vert    = (-h_ext) <<< msti_pkg::TIME_FRAC;
        cand_ak = in_step.ak + (a_ext <<< BIT);
        cand_g  = in_step.g + ((in_step.ak <<< 1) <<< BIT) + (a_ext <<< (2 * BIT))
                  + (h_ext <<< (msti_pkg::TIME_BITS + BIT));
        take    = (cand_ak <= vert) && !cand_g[GW-1];

        step_next = in_step;
        if (take)
        begin
            step_next.k  = in_step.k | (msti_pkg::TIME_BITS'(1) << BIT);
            step_next.ak = cand_ak;
            step_next.g  = cand_g;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step_reg <= step_next;
        end
    end

    assign valid = valid_reg;
    assign step  = step_reg;

endmodule

@@ hdl/moving_sphere_time_of_impact.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   in_data  (msti_pkg::in_t)
// out      output     out_valid / out_stall out_data (msti_pkg::out_t)
// cfg      input      cfg_write             cfg_data (collision radius, Q15.16)
//
// One transaction per cycle unless stalled; 3 geometry stages, 3 discriminant
// stages, 17 root-search stages (one time bit each) and the output register.
// rst_n clears all valid bits and sets the radius to 1.0.
// Stalling a valid output freezes the whole pipeline; in_stall follows in the same cycle.
module moving_sphere_time_of_impact (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  msti_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output msti_pkg::out_t                    out_data,
    input  logic                              cfg_write,
    input  logic [msti_pkg::RADIUS_WIDTH-1:0] cfg_data
);

    localparam int STEPS = msti_pkg::TIME_BITS;

    logic                               advance;
    logic [msti_pkg::RADIUS_WIDTH-1:0]  radius_reg;
    logic [msti_pkg::RR_WIDTH-1:0]      rr_reg;

    logic                geom_valid;
    msti_pkg::moments_t  geom_moments;

    logic                chain_valid[STEPS+1];
    msti_pkg::step_t     chain_step[STEPS+1];

    msti_pkg::out_t      out_next;
    msti_pkg::out_t      out_reg;
    logic                out_valid_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= msti_pkg::RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            radius_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= radius_reg * radius_reg;
    end

    msti_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data),
        .valid    (geom_valid),
        .moments  (geom_moments)
    );

    msti_disc u_disc (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (geom_valid),
        .moments  (geom_moments),
        .rr       (rr_reg),
        .valid    (chain_valid[0]),
        .step     (chain_step[0])
    );

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        msti_root_step #(
            .BIT (STEPS - 1 - s)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (chain_valid[s]),
            .in_step  (chain_step[s]),
            .valid    (chain_valid[s+1]),
            .step     (chain_step[s+1])
        );
    end

    always_comb
    begin
        out_next.impact_time = '0;
        if (chain_step[STEPS].overlap)
        begin
            out_next.contact_status = msti_pkg::STATUS_OVERLAP;
        end
        else if (chain_step[STEPS].hit)
        begin
            out_next.contact_status = msti_pkg::STATUS_HIT;
            out_next.impact_time    = chain_step[STEPS].k;
        end
        else
        begin
            out_next.contact_status = msti_pkg::STATUS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/msti_checker.sv @@
module msti_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input msti_pkg::out_t                    out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.contact_status != msti_pkg::STATUS_HIT)
        |-> out_data.impact_time == '0)
        else $error("impact time set without a hit");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.impact_time <= msti_pkg::TIME_ONE)
        else $error("impact time beyond the interval");

endmodule

bind moving_sphere_time_of_impact msti_checker u_msti_checker (.*);

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [199:0] wide_t;

    class contact_scoreboard;
        msti_pkg::out_t pending[$];
        logic [msti_pkg::RADIUS_WIDTH-1:0] radius = msti_pkg::RADIUS_RESET;
        int errors = 0;

        // true while k/65536 does not pass the earlier root
        function bit before_root(wide_t k, wide_t a, wide_t h, wide_t c);
            wide_t one;
            wide_t f;
            one = 65536;
            if (k * a > -h * one)
                return 0;
            f = a * k * k + h * k * one * 2 + c * one * one;
            return f >= 0;
        endfunction

        function msti_pkg::out_t contact_of(msti_pkg::in_t p);
            wide_t d[3];
            wide_t v[3];
            wide_t p0[3];
            wide_t p1[3];
            wide_t q0[3];
            wide_t q1[3];
            wide_t c0, rr, c, a, h, disc, f1, lo, hi, mid;
            msti_pkg::out_t r;
            p0 = '{wide_t'(p.first_start_x), wide_t'(p.first_start_y), wide_t'(p.first_start_z)};
            p1 = '{wide_t'(p.first_end_x), wide_t'(p.first_end_y), wide_t'(p.first_end_z)};
            q0 = '{wide_t'(p.second_start_x), wide_t'(p.second_start_y),
                   wide_t'(p.second_start_z)};
            q1 = '{wide_t'(p.second_end_x), wide_t'(p.second_end_y), wide_t'(p.second_end_z)};
            c0 = 0;
            a = 0;
            h = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = p0[i] - q0[i];
                v[i] = (p1[i] - p0[i]) - (q1[i] - q0[i]);
                c0 += d[i] * d[i];
                a += v[i] * v[i];
                h += d[i] * v[i];
            end
            r.contact_status = msti_pkg::STATUS_NONE;
            r.impact_time = '0;
            rr = wide_t'({1'b0, radius}) * wide_t'({1'b0, radius});
            if (c0 <= rr)
            begin
                r.contact_status = msti_pkg::STATUS_OVERLAP;
                return r;
            end
            c = c0 - rr;
            if (a == 0 || h >= 0)
                return r;
            disc = h * h - a * c;
            if (disc < 0)
                return r;
            f1 = a + h + h + c;
            if (!(f1 <= 0 || -h <= a))
                return r;
            lo = 0;
            hi = 65536;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (before_root(mid, a, h, c))
                    lo = mid;
                else
                    hi = mid - 1;
            end
            r.contact_status = msti_pkg::STATUS_HIT;
            r.impact_time = lo[msti_pkg::TIME_BITS-1:0];
            return r;
        endfunction

        function void note_pair(msti_pkg::in_t p);
            pending.push_back(contact_of(p));
        endfunction

        function void check_result(msti_pkg::out_t got);
            msti_pkg::out_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected transaction: status %0d time %0d",
                       got.contact_status, got.impact_time);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.contact_status !== exp_r.contact_status)
            begin
                $error("contact_status expected %0d actual %0d",
                       exp_r.contact_status, got.contact_status);
                errors++;
            end
            if (got.impact_time !== exp_r.impact_time)
            begin
                $error("impact_time expected %0d actual %0d",
                       exp_r.impact_time, got.impact_time);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    msti_pkg::in_t in_data;
    logic out_valid;
    logic out_stall;
    msti_pkg::out_t out_data;
    logic cfg_write;
    logic [msti_pkg::RADIUS_WIDTH-1:0] cfg_data;

    int idle_pct = 0;
    int stall_pct = 0;
    contact_scoreboard sb = new();

    moving_sphere_time_of_impact u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    task automatic send_pair(msti_pkg::in_t p);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pair(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_radius(logic [msti_pkg::RADIUS_WIDTH-1:0] r);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.radius = r;
    endtask

    function automatic msti_pkg::in_t pair_of(int ax, int ay, int az, int bx, int by, int bz,
                                              int cx, int cy, int cz, int ex, int ey, int ez);
        msti_pkg::in_t p;
        p = '{ax, ay, az, bx, by, bz, cx, cy, cz, ex, ey, ez};
        return p;
    endfunction

    function automatic int jitter(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic msti_pkg::in_t random_pair();
        msti_pkg::in_t p;
        int s, bx, by, bz;
        case ($urandom_range(3))
            0:
            begin
                p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            1:
            begin
                // second body parked, first body flies through it
                s = 1 << $urandom_range(14, 22);
                bx = jitter(1 << 26);
                by = jitter(1 << 26);
                bz = jitter(1 << 26);
                p = pair_of(bx + jitter(4 * s), by + jitter(4 * s), bz + jitter(4 * s),
                            bx + jitter(s / 2), by + jitter(s / 2), bz + jitter(s / 2),
                            bx, by, bz, bx, by, bz);
                if ($urandom_range(1))
                begin
                    p.first_end_x = 2 * bx - p.first_start_x + jitter(s / 4);
                    p.first_end_y = 2 * by - p.first_start_y + jitter(s / 4);
                    p.first_end_z = 2 * bz - p.first_start_z + jitter(s / 4);
                end
            end
            default:
            begin
                s = 1 << $urandom_range(12, 28);
                bx = jitter(1 << 28);
                by = jitter(1 << 28);
                bz = jitter(1 << 28);
                p = pair_of(bx + jitter(s), by + jitter(s), bz + jitter(s),
                            bx + jitter(s), by + jitter(s), bz + jitter(s),
                            bx + jitter(s), by + jitter(s), bz + jitter(s),
                            bx + jitter(s), by + jitter(s), bz + jitter(s));
            end
        endcase
        return p;
    endfunction

    localparam int MAXC = 32'h7fffffff;
    localparam int MINC = 32'h80000000;
    localparam int ONE = 65536;

    initial
    begin
        int idle_set[4];
        int stall_set[4];
        logic [msti_pkg::RADIUS_WIDTH-1:0] radius_set[4];
        idle_set = '{0, 79, 0, 28};
        stall_set = '{0, 0, 79, 28};
        radius_set = '{0, {msti_pkg::RADIUS_WIDTH{1'b1}},
                       msti_pkg::RADIUS_WIDTH'(3 * ONE / 2), msti_pkg::RADIUS_RESET};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset radius of 1.0
        send_pair(pair_of(0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, 0));             // touching
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 2 * ONE, 0, 0, 2 * ONE, 0, 0));     // no motion
        send_pair(pair_of(0, 0, 0, ONE, 0, 0, 3 * ONE, 0, 0, 3 * ONE, 0, 0));   // stops short of contact
        send_pair(pair_of(0, 0, 0, 4 * ONE, 0, 0, 3 * ONE, 0, 0, 3 * ONE, 0, 0));
        send_pair(pair_of(0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE, 0, 3 * ONE, 3 * ONE, 0));
        send_pair(pair_of(0, 0, 0, ONE / 2, 0, 0, 3 * ONE, 0, 0, 3 * ONE, 0, 0)); // past 1
        send_pair(pair_of(0, 0, 0, -ONE, 0, 0, 3 * ONE, 0, 0, 3 * ONE, 0, 0));    // receding
        send_pair(pair_of(0, 0, 0, 8 * ONE, 0, 0, 4 * ONE, 2 * ONE, 0, 4 * ONE, 2 * ONE, 0));
        send_pair(pair_of(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC,
                          MAXC, MAXC, MAXC));
        send_pair(pair_of(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                          MINC, MINC, MINC));
        send_pair(pair_of(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC,
                          MINC, MAXC, MINC));
        send_pair(pair_of(MINC, 0, 0, MAXC, 0, 0, MAXC, 0, 0, MINC, 0, 0));
        send_pair(pair_of(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_radius(radius_set[ph]);
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
            for (int n = 0; n < 80; n++)
                send_pair(random_pair());
            drain();
            set_radius(msti_pkg::RADIUS_WIDTH'($urandom_range(0, 1 << 20)));
            for (int n = 0; n < 80; n++)
                send_pair(random_pair());
            drain();
        end
        stall_pct = 0;
        repeat (30) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
